/* rtl/sedd_pkg.sv */
// Package for the source encoding declaration detector.
// Holds the name store sizing, status codes and the structs passed between
// the scanner, the decision queue and the emitter. No dependencies.
package sedd_pkg;

  // Name store capacity and derived widths
  localparam int NAME_CAPACITY = 32;
  localparam int NAME_IDX_W    = $clog2(NAME_CAPACITY);
  localparam int NAME_LEN_W    = $clog2(NAME_CAPACITY + 1);

  // Status reported with each result beat
  typedef enum logic [1:0] {
    ST_DEFAULT  = 2'd0,
    ST_DECLARED = 2'd1,
    ST_CONFLICT = 2'd2,
    ST_LONG     = 2'd3
  } status_t;

  // One decision: length 0 means a single item without a name character
  typedef struct packed {
    status_t                 status;
    logic                    bom;
    logic [NAME_LEN_W-1:0]   len;
  } cmd_t;

  // Name store write port
  typedef struct packed {
    logic                    en;
    logic [NAME_IDX_W-1:0]   addr;
    logic [6:0]              data;
  } wr_t;

  // Backpressure seen by the scanner
  typedef struct packed {
    logic full;   // decision queue cannot take another entry
    logic busy;   // name store still owned by queued or running decisions
  } flow_t;

endpackage

/* rtl/sedd_intf.sv */
// Valid/ready channel interfaces for the encoding declaration detector.
// sedd_in_if carries source bytes, sedd_out_if carries result beats.
// No dependencies.
interface sedd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       first_of_source;
  logic       last_of_source;

  modport source (output valid, output text_byte, output first_of_source,
                  output last_of_source, input ready);
  modport sink   (input valid, input text_byte, input first_of_source,
                  input last_of_source, output ready);
endinterface

interface sedd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] name_char;
  logic [1:0] status;
  logic       bom_found;
  logic       last_in_run;

  modport source (output valid, output name_char, output status,
                  output bom_found, output last_in_run, input ready);
  modport sink   (input valid, input name_char, input status,
                  input bom_found, input last_in_run, output ready);
endinterface

/* rtl/sedd_front.sv */
// Scanner: takes source bytes, tracks the BOM and the declaration syntax,
// writes name characters to the name store and pushes one decision per source.
// Depends on sedd_pkg and sedd_in_if.
module sedd_front (
  input  logic                clk,
  input  logic                rst,
  sedd_in_if.sink             text,
  input  sedd_pkg::flow_t     flow,
  output logic                push,
  output sedd_pkg::cmd_t      push_cmd,
  output sedd_pkg::wr_t       wr
);

  localparam int LW = sedd_pkg::NAME_LEN_W;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LC_C  = 8'h63;
  localparam logic [7:0] BOM_B0   = 8'hEF;
  localparam logic [7:0] BOM_B1   = 8'hBB;
  localparam logic [7:0] BOM_B2   = 8'hBF;

  typedef enum logic [2:0] {
    PH_COMMENT, PH_CODING, PH_OPERATOR, PH_BLANKS, PH_NAME
  } phase_t;

  typedef enum logic [1:0] {GO_ON, GO_DEFAULT, GO_NAME, GO_LONG} go_t;

  // "coding", one character per index
  function automatic logic [7:0] kw_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = 8'h63;
      3'd1:    r = 8'h6F;
      3'd2:    r = 8'h64;
      3'd3:    r = 8'h69;
      3'd4:    r = 8'h6E;
      3'd5:    r = 8'h67;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // "utf-8"
  function automatic logic [6:0] utf_dash_char(input logic [2:0] i);
    logic [6:0] r;
    case (i)
      3'd0:    r = 7'h75;
      3'd1:    r = 7'h74;
      3'd2:    r = 7'h66;
      3'd3:    r = 7'h2D;
      3'd4:    r = 7'h38;
      default: r = 7'h00;
    endcase
    return r;
  endfunction

  // "utf8"
  function automatic logic [6:0] utf_plain_char(input logic [2:0] i);
    logic [6:0] r;
    case (i)
      3'd0:    r = 7'h75;
      3'd1:    r = 7'h74;
      3'd2:    r = 7'h66;
      3'd3:    r = 7'h38;
      default: r = 7'h00;
    endcase
    return r;
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return c == 8'h2D || c == 8'h5F || c == 8'h2E ||
           (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic [6:0] to_lower(input logic [6:0] c);
    return (c >= 7'h41 && c <= 7'h5A) ? c + 7'd32 : c;
  endfunction

  phase_t          phase, phase_next;
  logic            line_idx, line_next;
  logic [2:0]      kw, kw_next;
  logic            pending_cr, pcr_next;
  logic [1:0]      bom_prog, bomp_next;
  logic            bom_seen, boms_next;
  logic [LW-1:0]   name_len, len_next;
  logic            m5, m5_next;   // name so far is a prefix of utf-8
  logic            m4, m4_next;   // name so far is a prefix of utf8
  logic            decided, dec_next;

  go_t             go;
  logic            accept;
  logic            do_scan;
  logic            do_seek;
  logic            do_name;
  logic [7:0]      c;
  logic [6:0]      lc;
  logic            is5, is4;

  // Stall when the queue is full, or when a name write could hit the store
  // while earlier decisions still read it.
  assign text.ready = !flow.full &&
                      !(flow.busy && !decided &&
                        (phase == PH_BLANKS || phase == PH_NAME));
  assign accept = text.valid && text.ready;
  assign c      = text.text_byte;
  assign lc     = to_lower(c[6:0]);

  // Next-state and decision logic for one accepted byte
  always_comb begin
    phase_next = phase;
    line_next  = line_idx;
    kw_next    = kw;
    pcr_next   = pending_cr;
    bomp_next  = bom_prog;
    boms_next  = bom_seen;
    len_next   = name_len;
    m5_next    = m5;
    m4_next    = m4;
    dec_next   = decided;
    go         = GO_ON;
    do_scan    = 1'b0;
    do_seek    = 1'b0;
    do_name    = 1'b0;
    is5        = 1'b0;
    is4        = 1'b0;
    push       = 1'b0;
    push_cmd   = '0;
    wr         = '0;

    if (accept) begin
      if (text.first_of_source) begin
        phase_next = PH_COMMENT;
        line_next  = 1'b0;
        kw_next    = '0;
        pcr_next   = 1'b0;
        bomp_next  = '0;
        boms_next  = 1'b0;
        len_next   = '0;
        m5_next    = 1'b0;
        m4_next    = 1'b0;
        dec_next   = 1'b0;
      end

      if (!dec_next) begin
        // Byte order mark
        case (bomp_next)
          2'd0: begin
            if (c == BOM_B0) begin
              bomp_next = 2'd1;
            end else begin
              bomp_next = 2'd3;
              do_scan   = 1'b1;
            end
          end
          2'd1: begin
            if (c == BOM_B1) bomp_next = 2'd2;
            else go = GO_DEFAULT;
          end
          2'd2: begin
            if (c == BOM_B2) begin
              bomp_next = 2'd3;
              boms_next = 1'b1;
            end else begin
              go = GO_DEFAULT;
            end
          end
          default: do_scan = 1'b1;
        endcase

        // Declaration syntax
        if (do_scan) begin
          if (pcr_next) begin
            pcr_next = 1'b0;
            if (c != CH_LF) go = GO_DEFAULT;
          end else begin
            unique case (phase_next)
              PH_COMMENT: begin
                if (c == CH_HASH) begin
                  phase_next = PH_CODING;
                  kw_next    = '0;
                end else if (c == CH_CR) begin
                  pcr_next = 1'b1;
                end else if (c != CH_LF && c != CH_SP && c != CH_TAB &&
                             c != CH_FF) begin
                  go = GO_DEFAULT;
                end
              end
              PH_CODING: do_seek = 1'b1;
              PH_OPERATOR: begin
                if (c == CH_EQ || c == CH_COLON) begin
                  phase_next = PH_BLANKS;
                end else begin
                  phase_next = PH_CODING;
                  kw_next    = '0;
                  do_seek    = 1'b1;
                end
              end
              PH_BLANKS: begin
                if (c != CH_SP && c != CH_TAB) do_name = 1'b1;
              end
              PH_NAME: do_name = 1'b1;
              default: go = GO_DEFAULT;
            endcase

            // Match "coding", a failed character may restart it
            if (do_seek) begin
              if (c == kw_char(kw_next)) begin
                if (kw_next == 3'd5) begin
                  kw_next    = '0;
                  phase_next = PH_OPERATOR;
                end else begin
                  kw_next = kw_next + 3'd1;
                end
              end else begin
                kw_next = (c == CH_LC_C) ? 3'd1 : 3'd0;
              end
            end

            // Collect name characters
            if (do_name) begin
              phase_next = PH_NAME;
              if (is_name_char(c)) begin
                if (len_next >= LW'(sedd_pkg::NAME_CAPACITY)) begin
                  go = GO_LONG;
                end else begin
                  wr.en   = 1'b1;
                  wr.addr = len_next[sedd_pkg::NAME_IDX_W-1:0];
                  wr.data = c[6:0];
                  if (len_next < LW'(5))
                    m5_next = (len_next == '0 || m5_next) &&
                              lc == utf_dash_char(len_next[2:0]);
                  else
                    m5_next = 1'b0;
                  if (len_next < LW'(4))
                    m4_next = (len_next == '0 || m4_next) &&
                              lc == utf_plain_char(len_next[2:0]);
                  else
                    m4_next = 1'b0;
                  len_next = len_next + LW'(1);
                end
              end else if (len_next != '0) begin
                go = GO_NAME;
              end else begin
                phase_next = PH_CODING;
                kw_next    = '0;
              end
            end
          end

          // End of line: second line ends the search
          if (go == GO_ON && c == CH_LF) begin
            if (line_next) begin
              go = GO_DEFAULT;
            end else begin
              line_next  = 1'b1;
              phase_next = PH_COMMENT;
              kw_next    = '0;
            end
          end
        end

        // End of source forces a decision
        if (go == GO_ON && text.last_of_source) begin
          if (bomp_next == 2'd3 && !pcr_next && phase_next == PH_NAME &&
              len_next != '0)
            go = GO_NAME;
          else
            go = GO_DEFAULT;
        end

        // Hand the decision to the emitter
        if (go != GO_ON) begin
          dec_next     = 1'b1;
          push         = 1'b1;
          push_cmd.bom = boms_next;
          if (go == GO_NAME) begin
            is5          = m5_next && len_next == LW'(5);
            is4          = m4_next && len_next == LW'(4);
            push_cmd.len = len_next;
            push_cmd.status = (boms_next && !is5 && !is4) ?
                              sedd_pkg::ST_CONFLICT : sedd_pkg::ST_DECLARED;
          end else begin
            push_cmd.len    = '0;
            push_cmd.status = (go == GO_LONG) ? sedd_pkg::ST_LONG :
                                                sedd_pkg::ST_DEFAULT;
          end
        end
      end
    end
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_COMMENT;
      line_idx   <= 1'b0;
      kw         <= '0;
      pending_cr <= 1'b0;
      bom_prog   <= '0;
      bom_seen   <= 1'b0;
      name_len   <= '0;
      m5         <= 1'b0;
      m4         <= 1'b0;
      decided    <= 1'b0;
    end else begin
      phase      <= phase_next;
      line_idx   <= line_next;
      kw         <= kw_next;
      pending_cr <= pcr_next;
      bom_prog   <= bomp_next;
      bom_seen   <= boms_next;
      name_len   <= len_next;
      m5         <= m5_next;
      m4         <= m4_next;
      decided    <= dec_next;
    end
  end

endmodule

/* rtl/sedd_queue.sv */
// Two-entry decision queue between the scanner and the emitter.
// Depends on sedd_pkg.
module sedd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sedd_pkg::cmd_t   push_cmd,
  input  logic             pop,
  output sedd_pkg::cmd_t   head,
  output logic             empty,
  output logic             full
);

  sedd_pkg::cmd_t entry [2];
  logic           wp, rp;
  logic [1:0]     count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = entry[rp];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entry[wp] <= push_cmd;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/sedd_back.sv */
// Emitter: owns the name store, takes decisions from the queue and plays
// each out as a run of result beats. Depends on sedd_pkg and sedd_out_if.
module sedd_back (
  input  logic             clk,
  input  logic             rst,
  input  sedd_pkg::wr_t    wr,
  input  logic             empty,
  input  sedd_pkg::cmd_t   head,
  output logic             pop,
  output logic             busy,
  sedd_out_if.source       result
);

  localparam int IW = sedd_pkg::NAME_IDX_W;
  localparam int LW = sedd_pkg::NAME_LEN_W;

  typedef enum logic {S_IDLE, S_SHOW} state_t;

  logic [6:0]      store [sedd_pkg::NAME_CAPACITY];
  logic [6:0]      rdata;
  logic [IW-1:0]   rd_addr;

  state_t          state;
  sedd_pkg::cmd_t  cur;
  logic [IW-1:0]   k;
  logic            take;
  logic            last;

  assign pop  = (state == S_IDLE) && !empty;
  assign busy = (state == S_SHOW);
  assign take = result.valid && result.ready;
  assign last = (cur.len == '0) || (LW'(k) + LW'(1) == cur.len);

  // Look one entry ahead when the current beat is taken
  always_comb begin
    if (state == S_IDLE)
      rd_addr = '0;
    else if (take)
      rd_addr = k + IW'(1);
    else
      rd_addr = k;
  end

  // Name store, registered read
  always_ff @(posedge clk) begin
    if (wr.en) store[wr.addr] <= wr.data;
    rdata <= store[rd_addr];
  end

  assign result.valid       = (state == S_SHOW);
  assign result.name_char   = (cur.len == '0) ? 7'd0 : rdata;
  assign result.status      = cur.status;
  assign result.bom_found   = cur.bom;
  assign result.last_in_run = last;

  // Run sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            cur   <= head;
            k     <= '0;
            state <= S_SHOW;
          end
        end
        S_SHOW: begin
          if (take) begin
            if (last) state <= S_IDLE;
            else k <= k + IW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/source_encoding_declaration_detect.sv */
// Top level of the source encoding declaration detector.
// Depends on sedd_pkg, sedd_intf, sedd_front, sedd_queue and sedd_back.
//
// Usage:
//   text carries one source byte per beat with first_of_source and
//   last_of_source marks. result carries the decision as a run of beats:
//   the declared name one character per beat, or a single beat with
//   name_char 0 (default utf-8 or name too long); last_in_run closes a run.
//   The scanner takes one byte per cycle while text.ready is high. A decision
//   enters a two-entry queue; the emitter takes it from there when idle,
//   then gives one beat per cycle while the receiver is ready, and
//   goes idle again between runs. Throughput is bounded by the scanner
//   (1 byte/cycle) except that while any decision is still queued or
//   playing, bytes that could write a name character wait, since the
//   name store holds a single name that the emitter may still be reading.
//   Reset clears the scanner, queue and emitter; the name store is not
//   cleared, only characters written for the current source are read.
//   When the receiver stalls, the run holds; the scanner keeps going until
//   the queue fills or a name byte must wait, then text.ready drops.
module source_encoding_declaration_detect (
  input  logic        clk,
  input  logic        rst,
  sedd_in_if.sink     text,
  sedd_out_if.source  result
);

  logic             push;
  sedd_pkg::cmd_t   push_cmd;
  sedd_pkg::cmd_t   head;
  sedd_pkg::wr_t    wr;
  sedd_pkg::flow_t  flow;
  logic             pop;
  logic             empty;
  logic             full;
  logic             back_busy;

  assign flow.full = full;
  assign flow.busy = !empty || back_busy;

  sedd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .text     (text),
    .flow     (flow),
    .push     (push),
    .push_cmd (push_cmd),
    .wr       (wr)
  );

  sedd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  sedd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .busy   (back_busy),
    .result (result)
  );

endmodule
